FILE: hw/rtl/bri_pkg.sv
// Shared types and constants of the BMP RLE palette-index decoder.
`default_nettype none
package bri_pkg;

	localparam int unsigned MAX_DIM_DEF = 4096;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned NIB_SHIFT   = 4;
	localparam logic [7:0]  NIB_MASK    = 8'h0F;

	typedef enum logic [2:0] {
		PH_COUNT  = 3'd0,
		PH_SECOND = 3'd1,
		PH_DX     = 3'd2,
		PH_DY     = 3'd3,
		PH_LIT    = 3'd4,
		PH_PAD    = 3'd5
	} bri_phase_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_END   = 2'd1,
		ST_TRUNC = 2'd2,
		ST_OOB   = 2'd3
	} bri_status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_TOP_FIRST = 2'd2,
		REG_FOUR_BIT  = 2'd3
	} bri_reg_t;

	typedef struct packed {
		logic        write_valid;
		logic [11:0] out_row;
		logic [11:0] start_column;
		logic [7:0]  pixel_count;
		logic [7:0]  even_index;
		logic [7:0]  odd_index;
		bri_status_t status;
	} bri_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bri_in_if.sv
// Compressed byte stream channel.
`default_nettype none
interface bri_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;
	logic       last_byte;

	modport source(output valid, output stream_byte, output last_byte, input ready);
	modport sink(input valid, input stream_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bri_out_if.sv
// Pixel run result channel.
`default_nettype none
interface bri_out_if;
	logic        valid;
	logic        ready;
	logic        write_valid;
	logic [11:0] out_row;
	logic [11:0] start_column;
	logic [7:0]  pixel_count;
	logic [7:0]  even_index;
	logic [7:0]  odd_index;
	logic [1:0]  status;

	modport source(output valid, output write_valid, output out_row, output start_column,
		output pixel_count, output even_index, output odd_index, output status, input ready);
	modport sink(input valid, input write_valid, input out_row, input start_column,
		input pixel_count, input even_index, input odd_index, input status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bri_cfg_if.sv
// Configuration register write channel.
`default_nettype none
interface bri_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bri_pkg::CFG_INDEX_W-1:0]  index;
	logic [bri_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bri_parser.sv
// Parse state and run/escape decode for one stream byte per cycle while adv is high.
`default_nettype none
module bri_parser #(
	parameter int unsigned MAX_DIM = bri_pkg::MAX_DIM_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic [7:0]                   item_byte,
	input  wire logic                         item_last,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] cfg_width,
	input  wire logic [$clog2(MAX_DIM+1)-1:0] cfg_height,
	input  wire logic                         cfg_top_first,
	input  wire logic                         cfg_four_bit,
	output logic                              has_result,
	output bri_pkg::bri_result_t              result
);
	import bri_pkg::*;

	// cursor holds up to MAX_DIM plus one delta step, with headroom for a run add
	localparam int unsigned CW = $clog2(MAX_DIM + 256) + 1;

	bri_phase_t    phase_q, phase_d;
	logic [CW-1:0] col_q, col_d;
	logic [CW-1:0] row_q, row_d;
	logic [7:0]    held_q, held_d;
	logic [7:0]    left_q, left_d;
	logic          odd_q, odd_d;
	logic          halted_q, halted_d;

	logic [CW-1:0] w_ext, h_ext, row_inc, row_add, out_r;
	logic [7:0]    hi, lo, run_n, left_sub;
	logic          run_req, run_oob, esc_oob, esc_end;
	bri_result_t   res;
	logic          has;

	assign w_ext    = CW'(cfg_width);
	assign h_ext    = CW'(cfg_height);
	assign hi       = cfg_four_bit ? (8'(item_byte >> NIB_SHIFT) & NIB_MASK) : item_byte;
	assign lo       = cfg_four_bit ? (item_byte & NIB_MASK) : item_byte;
	assign row_inc  = row_q + CW'(1);
	assign row_add  = row_q + CW'(item_byte);
	assign run_oob  = (row_q >= h_ext) || ((col_q + CW'(run_n)) > w_ext);
	assign out_r    = cfg_top_first ? row_q : (h_ext - CW'(1) - row_q);
	assign left_sub = (cfg_four_bit && left_q >= 8'd2) ? 8'd2 : 8'd1;

	always_comb begin
		phase_d  = phase_q;
		col_d    = col_q;
		row_d    = row_q;
		held_d   = held_q;
		left_d   = left_q;
		odd_d    = odd_q;
		halted_d = halted_q;
		run_req  = 1'b0;
		run_n    = 8'd0;
		esc_oob  = 1'b0;
		esc_end  = 1'b0;
		has      = 1'b0;
		res      = '0;

		case (phase_q)
			PH_SECOND: begin
				phase_d = PH_COUNT;
				if (held_q != 8'd0) begin
					run_req = 1'b1;
					run_n   = held_q;
				end else if (item_byte == 8'd0) begin
					col_d   = '0;
					row_d   = row_inc;
					esc_oob = row_inc > h_ext;
				end else if (item_byte == 8'd1) begin
					esc_end = 1'b1;
				end else if (item_byte == 8'd2) begin
					phase_d = PH_DX;
				end else begin
					left_d  = item_byte;
					odd_d   = 1'b0;
					phase_d = PH_LIT;
				end
			end
			PH_DX: begin
				col_d   = col_q + CW'(item_byte);
				phase_d = PH_DY;
			end
			PH_DY: begin
				row_d   = row_add;
				phase_d = PH_COUNT;
				esc_oob = (col_q > w_ext) || (row_add >= h_ext);
			end
			PH_LIT: begin
				if (left_q == 8'd0) begin
					phase_d = PH_COUNT;
				end else begin
					run_req = 1'b1;
					run_n   = left_sub;
					left_d  = left_q - left_sub;
					odd_d   = ~odd_q;
					if (left_q == left_sub)
						phase_d = (~odd_q) ? PH_PAD : PH_COUNT;
				end
			end
			PH_PAD: begin
				phase_d = PH_COUNT;
			end
			default: begin
				held_d  = item_byte;
				phase_d = PH_SECOND;
			end
		endcase

		if (run_req) begin
			has = 1'b1;
			if (run_oob) begin
				res.status = ST_OOB;
				halted_d   = 1'b1;
			end else begin
				res.write_valid  = 1'b1;
				res.out_row      = 12'(out_r);
				res.start_column = 12'(col_q);
				res.pixel_count  = run_n;
				res.even_index   = hi;
				res.odd_index    = lo;
				res.status       = ST_OK;
				col_d            = col_q + CW'(run_n);
			end
		end else if (esc_oob) begin
			has        = 1'b1;
			res.status = ST_OOB;
			halted_d   = 1'b1;
		end else if (esc_end) begin
			has        = 1'b1;
			res.status = ST_END;
			halted_d   = 1'b1;
		end

		if (halted_q) begin
			has      = 1'b0;
			res      = '0;
			phase_d  = phase_q;
			col_d    = col_q;
			row_d    = row_q;
			held_d   = held_q;
			left_d   = left_q;
			odd_d    = odd_q;
			halted_d = halted_q;
		end else if (item_last && !(has && (res.status == ST_END || res.status == ST_OOB))) begin
			has        = 1'b1;
			res        = '0;
			res.status = ST_TRUNC;
		end

		// last byte always returns the parser to its reset state
		if (item_last) begin
			phase_d  = PH_COUNT;
			col_d    = '0;
			row_d    = '0;
			held_d   = 8'd0;
			left_d   = 8'd0;
			odd_d    = 1'b0;
			halted_d = 1'b0;
		end
	end

	assign has_result = has;
	assign result     = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= 8'd0;
			left_q   <= 8'd0;
			odd_q    <= 1'b0;
			halted_q <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			col_q    <= col_d;
			row_q    <= row_d;
			held_q   <= held_d;
			left_q   <= left_d;
			odd_q    <= odd_d;
			halted_q <= halted_d;
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_last |=> phase_q == PH_COUNT && !halted_q && col_q == '0 && row_q == '0)
		else $error("parser state not cleared after last byte");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !has_result)
		else $error("result produced while stream halted");

	a_write_in_width: assert property (@(posedge clk) disable iff (!arst_n)
		has_result && result.write_valid |-> (col_q + CW'(result.pixel_count)) <= w_ext)
		else $error("run written past image width");

endmodule
`default_nettype wire

FILE: hw/rtl/bmp_rle_index_decoder.sv
// Top level of the BMP RLE8/RLE4 palette-index run decoder.
// Takes one compressed byte per cycle on stream and gives at most one run word per byte on
// runs. An accepted byte goes into an input register, the parser updates its cursor and phase
// and forms the result combinationally, and the result sits in an output register; a new byte
// is taken every cycle as long as runs keeps taking words. The parser state update sets the
// rate. cfg is always ready; write it only while no byte is in flight. Width and height above
// MAX_DIM are stored as MAX_DIM.
`default_nettype none
module bmp_rle_index_decoder #(
	parameter int unsigned MAX_DIM = bri_pkg::MAX_DIM_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bri_in_if.sink   stream,
	bri_out_if.source runs,
	bri_cfg_if.sink  cfg
);
	import bri_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DIM + 1);

	logic [DW-1:0] width_q, height_q, cfg_dim;
	logic          top_first_q, four_bit_q;

	logic          s1_valid_q, s1_last_s1;
	logic [7:0]    s1_byte_s1;
	logic          s1_adv, in_ready;

	logic          has_result;
	bri_result_t   result;
	logic          out_valid_q;
	bri_result_t   out_q;

	// config writes
	assign cfg.ready = 1'b1;
	assign cfg_dim   = (32'(cfg.data) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DW'(1);
			height_q    <= DW'(1);
			top_first_q <= 1'b0;
			four_bit_q  <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH:     width_q     <= cfg_dim;
				REG_HEIGHT:    height_q    <= cfg_dim;
				REG_TOP_FIRST: top_first_q <= cfg.data[0];
				REG_FOUR_BIT:  four_bit_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// input register
	assign s1_adv       = s1_valid_q && (!out_valid_q || runs.ready);
	assign in_ready     = !s1_valid_q || s1_adv;
	assign stream.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_ready)
			s1_valid_q <= stream.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && stream.valid) begin
			s1_byte_s1 <= stream.stream_byte;
			s1_last_s1 <= stream.last_byte;
		end
	end

	bri_parser #(
		.MAX_DIM(MAX_DIM)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (s1_adv),
		.item_byte    (s1_byte_s1),
		.item_last    (s1_last_s1),
		.cfg_width    (width_q),
		.cfg_height   (height_q),
		.cfg_top_first(top_first_q),
		.cfg_four_bit (four_bit_q),
		.has_result   (has_result),
		.result       (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= has_result;
		else if (runs.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_result)
			out_q <= result;
	end

	assign runs.valid        = out_valid_q;
	assign runs.write_valid  = out_q.write_valid;
	assign runs.out_row      = out_q.out_row;
	assign runs.start_column = out_q.start_column;
	assign runs.pixel_count  = out_q.pixel_count;
	assign runs.even_index   = out_q.even_index;
	assign runs.odd_index    = out_q.odd_index;
	assign runs.status       = out_q.status;

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.write_valid |-> out_q.pixel_count == 8'd0
			&& out_q.out_row == 12'd0 && out_q.start_column == 12'd0)
		else $error("non-write word carries run fields");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.write_valid |-> out_q.status == ST_OK && out_q.pixel_count != 8'd0)
		else $error("write word with bad status or empty run");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_s1) && $stable(s1_last_s1))
		else $error("stalled input byte lost");

	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !runs.ready |=> out_valid_q && $stable(out_q))
		else $error("stalled result word changed");

endmodule
`default_nettype wire

FILE: sim/bri_tb_pkg.sv
// Escape byte codes of the RLE pixel stream, shared by the bench and its run checker.
`timescale 1ns / 100ps
package bri_tb_pkg;

	localparam logic [7:0] ESC_MARK  = 8'd0;
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_END   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

endpackage

FILE: sim/bri_run_check.sv
// Run checker: watches the decoder channels, predicts each run word and compares it.
`timescale 1ns / 100ps
module bri_run_check (
	input wire logic    clk,
	input wire logic    arst_n,
	bri_in_if           stream,
	bri_out_if          runs,
	bri_cfg_if          cfg,
	output int unsigned errors,
	output int unsigned pending
);
	import bri_pkg::*;
	import bri_tb_pkg::*;

	logic [12:0] img_w;
	logic [12:0] img_h;
	logic        top_first;
	logic        four_bit;
	bri_phase_t  phase;
	logic [13:0] col;
	logic [13:0] row;
	logic [7:0]  run_len;
	logic [7:0]  lit_left;
	logic        lit_odd;
	logic        halted;
	bri_result_t run_q[$];
	int unsigned err_cnt = 0;

	assign errors = err_cnt;

	function automatic void restart_parser();
		phase = PH_COUNT;
		col = '0;
		row = '0;
		run_len = '0;
		lit_left = '0;
		lit_odd = 1'b0;
		halted = 1'b0;
	endfunction

	function automatic logic [12:0] clamp_dim(input logic [12:0] v);
		return (v > 13'(MAX_DIM_DEF)) ? 13'(MAX_DIM_DEF) : v;
	endfunction

	function automatic bri_result_t status_only(input bri_status_t st);
		bri_result_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	function automatic bri_result_t overrun();
		halted = 1'b1;
		return status_only(ST_OOB);
	endfunction

	function automatic bri_result_t place_run(input logic [7:0] n, input logic [7:0] ev,
		input logic [7:0] od);
		logic [14:0] reach;
		logic [13:0] flip;
		bri_result_t r;
		reach = {1'b0, col} + 15'(n);
		if (row >= 14'(img_h) || reach > 15'(img_w))
			return overrun();
		flip = 14'(img_h) - 14'd1 - row;
		r = '0;
		r.write_valid = 1'b1;
		r.out_row = top_first ? row[11:0] : flip[11:0];
		r.start_column = col[11:0];
		r.pixel_count = n;
		r.even_index = ev;
		r.odd_index = od;
		r.status = ST_OK;
		col = col + 14'(n);
		return r;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output bri_result_t r);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] n;
		hi = four_bit ? ((b >> NIB_SHIFT) & NIB_MASK) : b;
		lo = four_bit ? (b & NIB_MASK) : b;
		r = '0;
		case (phase)
			PH_SECOND: begin
				phase = PH_COUNT;
				if (run_len != 8'd0) begin
					r = place_run(run_len, hi, lo);
					return 1'b1;
				end
				case (b)
					ESC_EOL: begin
						col = '0;
						row = row + 14'd1;
						if (row > 14'(img_h)) begin
							r = overrun();
							return 1'b1;
						end
						return 1'b0;
					end
					ESC_END: begin
						halted = 1'b1;
						r = status_only(ST_END);
						return 1'b1;
					end
					ESC_DELTA: begin
						phase = PH_DX;
						return 1'b0;
					end
					default: begin
						lit_left = b;
						lit_odd = 1'b0;
						phase = PH_LIT;
						return 1'b0;
					end
				endcase
			end
			PH_DX: begin
				col = col + 14'(b);
				phase = PH_DY;
				return 1'b0;
			end
			PH_DY: begin
				row = row + 14'(b);
				phase = PH_COUNT;
				if (col > 14'(img_w) || row >= 14'(img_h)) begin
					r = overrun();
					return 1'b1;
				end
				return 1'b0;
			end
			PH_LIT: begin
				if (lit_left == 8'd0) begin
					phase = PH_COUNT;
					return 1'b0;
				end
				n = (four_bit && lit_left >= 8'd2) ? 8'd2 : 8'd1;
				lit_left = lit_left - n;
				lit_odd = ~lit_odd;
				if (lit_left == 8'd0)
					phase = lit_odd ? PH_PAD : PH_COUNT;
				r = place_run(n, hi, lo);
				return 1'b1;
			end
			PH_PAD: begin
				phase = PH_COUNT;
				return 1'b0;
			end
			default: begin
				run_len = b;
				phase = PH_SECOND;
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			err_cnt++;
			$display("%0t: run word %s expected %0h got %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bri_result_t want;
		bit          has;
		if (!arst_n) begin
			img_w = 13'd1;
			img_h = 13'd1;
			top_first = 1'b0;
			four_bit = 1'b0;
			restart_parser();
			run_q.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (bri_reg_t'(cfg.index))
					REG_WIDTH:     img_w = clamp_dim(cfg.data);
					REG_HEIGHT:    img_h = clamp_dim(cfg.data);
					REG_TOP_FIRST: top_first = cfg.data[0];
					REG_FOUR_BIT:  four_bit = cfg.data[0];
					default: ;
				endcase
			end
			if (stream.valid && stream.ready) begin
				if (halted) begin
					if (stream.last_byte)
						restart_parser();
				end else begin
					has = parse_byte(stream.stream_byte, want);
					if (stream.last_byte) begin
						if (!(has && (want.status == ST_END || want.status == ST_OOB))) begin
							has = 1'b1;
							want = status_only(ST_TRUNC);
						end
						restart_parser();
					end
					if (has)
						run_q.insert(run_q.size(), want);
				end
			end
			if (runs.valid && runs.ready) begin
				if (run_q.size() == 0) begin
					err_cnt++;
					$display("%0t: run word expected none got status %0h row %0h col %0h",
						$time, runs.status, runs.out_row, runs.start_column);
				end else begin
					want = run_q.pop_front();
					check_field("write_valid", 16'(want.write_valid), 16'(runs.write_valid));
					check_field("out_row", 16'(want.out_row), 16'(runs.out_row));
					check_field("start_column", 16'(want.start_column), 16'(runs.start_column));
					check_field("pixel_count", 16'(want.pixel_count), 16'(runs.pixel_count));
					check_field("even_index", 16'(want.even_index), 16'(runs.even_index));
					check_field("odd_index", 16'(want.odd_index), 16'(runs.odd_index));
					check_field("status", 16'(want.status), 16'(runs.status));
				end
			end
			pending <= run_q.size();
		end
	end

endmodule

FILE: sim/bmp_rle_index_decoder_tb.sv
// Decoder regression top: clock, reset, RLE byte streams, config phases and verdict.
`timescale 1ns / 100ps
module bmp_rle_index_decoder_tb;
	import bri_pkg::*;
	import bri_tb_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned PHASES       = 8;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n;
	int unsigned errors;
	int unsigned pending;
	int unsigned sent = 0;
	int unsigned cycles = 0;
	int unsigned tx_idle_pct = 7;
	int unsigned rx_idle_pct = 68;
	int unsigned hold_seq = 0;
	int unsigned cur_w;
	int unsigned cur_h;
	logic        cur_four_bit;
	logic [7:0]  byte_q[$];

	bri_in_if  stream_ch();
	bri_out_if runs_ch();
	bri_cfg_if cfg_ch();

	bmp_rle_index_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.runs   (runs_ch),
		.cfg    (cfg_ch)
	);

	bri_run_check run_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_ch),
		.runs    (runs_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bmp_rle_index_decoder regression: fail");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off each time hold_seq is bumped (phase 3)
	initial begin
		int unsigned hold_left;
		int unsigned seen;
		hold_left = 0;
		seen = 0;
		runs_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				runs_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				runs_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_seq != seen) begin
				seen = hold_seq;
				hold_left = HOLD_CYCLES;
				runs_ch.ready <= 1'b0;
			end else begin
				runs_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic void add_byte(input logic [7:0] b);
		byte_q.insert(byte_q.size(), b);
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			stream_ch.valid <= 1'b0;
			@(posedge clk);
		end
		stream_ch.valid <= 1'b1;
		stream_ch.stream_byte <= b;
		stream_ch.last_byte <= last;
		do @(posedge clk); while (!stream_ch.ready);
		sent++;
		if (sent == RANDOM_ITEMS / 3) begin
			tx_idle_pct = 68;
			rx_idle_pct = 7;
		end else if (sent == 2 * RANDOM_ITEMS / 3) begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	task automatic send_stream();
		for (int i = 0; i < byte_q.size(); i++)
			put_byte(byte_q[i], i == byte_q.size() - 1);
	endtask

	task automatic wr_reg(input bri_reg_t idx, input logic [12:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_config(input logic [12:0] w, input logic [12:0] h, input logic td,
		input logic fb);
		wr_reg(REG_WIDTH, w);
		wr_reg(REG_HEIGHT, h);
		wr_reg(REG_TOP_FIRST, {12'd0, td});
		wr_reg(REG_FOUR_BIT, {12'd0, fb});
		cfg_ch.valid <= 1'b0;
		cur_w = (w > MAX_DIM_DEF) ? MAX_DIM_DEF : w;
		cur_h = (h > MAX_DIM_DEF) ? MAX_DIM_DEF : h;
		cur_four_bit = fb;
	endtask

	task automatic drain();
		stream_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// builds one stream, mostly well formed for the current image size
	task automatic make_stream();
		int unsigned col;
		int unsigned row;
		int unsigned rem;
		int unsigned room;
		int unsigned n;
		int unsigned nb;
		int unsigned k;
		int unsigned lit_max;
		int unsigned dy_max;
		byte_q.delete();
		col = 0;
		row = 0;
		if ($urandom_range(99) < 6) begin
			repeat ($urandom_range(1, 16)) add_byte(8'($urandom));
			return;
		end
		repeat ($urandom_range(1, 10)) begin
			rem = (cur_w > col) ? cur_w - col : 0;
			room = (rem > 255) ? 255 : rem;
			k = $urandom_range(99);
			if (k < 35 && room != 0) begin
				n = $urandom_range(1, room);
				add_byte(8'(n));
				add_byte(8'($urandom));
				col += n;
			end else if (k < 60 && room >= 3) begin
				lit_max = (room < 24 || $urandom_range(9) == 0) ? room : 24;
				n = $urandom_range(3, lit_max);
				nb = cur_four_bit ? (n + 1) / 2 : n;
				add_byte(ESC_MARK);
				add_byte(8'(n));
				repeat (nb) add_byte(8'($urandom));
				if (nb % 2)
					add_byte(8'($urandom));
				col += n;
			end else if (k < 78 && row + 1 < cur_h) begin
				add_byte(ESC_MARK);
				add_byte(ESC_EOL);
				row++;
				col = 0;
			end else if (row < cur_h) begin
				dy_max = cur_h - 1 - row;
				if (dy_max > 255)
					dy_max = 255;
				n = $urandom_range(0, room);
				nb = $urandom_range(0, dy_max);
				add_byte(ESC_MARK);
				add_byte(ESC_DELTA);
				add_byte(8'(n));
				add_byte(8'(nb));
				col += n;
				row += nb;
			end
		end
		rem = (cur_w > col) ? cur_w - col : 0;
		k = $urandom_range(99);
		if (k < 80) begin
			add_byte(ESC_MARK);
			add_byte(ESC_END);
			if (k >= 72)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
		end else if (k < 92) begin
			if (byte_q.size() == 0)
				add_byte(8'($urandom));
		end else begin
			// overrun the row or step past the image
			if (rem < 255) begin
				add_byte(8'(rem + 1));
				add_byte(8'($urandom));
			end else begin
				add_byte(ESC_MARK);
				add_byte(ESC_DELTA);
				add_byte(8'd255);
				add_byte(8'd255);
			end
			repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
		end
	endtask

	initial begin
		int unsigned quota;
		stream_ch.valid <= 1'b0;
		stream_ch.stream_byte <= 8'd0;
		stream_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_WIDTH;
		cfg_ch.data <= 13'd0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// oversized width clamps; full-length run, odd literal with pad, far delta, EOL, end
		set_config(13'h1FFF, 13'd4096, 1'b0, 1'b0);
		byte_q = '{8'd255, 8'hAA, ESC_MARK, 8'd3, 8'h00, 8'hFF, 8'h5A, 8'h00,
			ESC_MARK, ESC_DELTA, 8'd255, 8'd255, ESC_MARK, ESC_EOL, ESC_MARK, ESC_END};
		send_stream();
		// last byte completes a run: truncated
		byte_q = '{8'd5, 8'd7};
		send_stream();
		drain();
		// RLE4 run wider than the image, then halted bytes until the last one
		set_config(13'd1, 13'd1, 1'b1, 1'b1);
		byte_q = '{8'd2, 8'h3C, 8'h77, 8'h00};
		send_stream();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_config(13'd4096, 13'd4096, 1'b1, 1'b1);
				1: set_config(13'd1, 13'd1, 1'b0, 1'b0);
				2: set_config(13'd0, 13'd0, 1'b1, 1'b0);
				3: set_config(13'($urandom_range(1, 40)), 13'($urandom_range(1, 12)), 1'b0, 1'b1);
				5: set_config(13'd4096, 13'd3, 1'b0, 1'b0);
				default: set_config(13'($urandom_range(1, 40)), 13'($urandom_range(1, 12)),
					1'($urandom), 1'($urandom));
			endcase
			if (p == 3)
				hold_seq++;
			quota = sent + ((p == 2) ? 40 : 200);
			while (sent < quota) begin
				make_stream();
				send_stream();
			end
			drain();
		end

		if (errors == 0)
			$display("bmp_rle_index_decoder regression: pass");
		else
			$display("bmp_rle_index_decoder regression: fail");
		$finish;
	end

endmodule
